### src/particle_pool_engine_assert.svh
// Assertion macros for the particle pool engine checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PARTICLE_POOL_ENGINE_ASSERT_SVH
`define PARTICLE_POOL_ENGINE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define PPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked implication: the consequent is checked in the cycle after the antecedent.
`define PPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ppe_pkg.sv
// Shared types, codes and helpers for the particle pool engine.
// No dependencies.
package ppe_pkg;

    localparam int unsigned ONE_Q16   = 65536;
    localparam int unsigned RECIP10   = 838861;  // ceil(2^23 / 10)
    localparam int unsigned RECIP10_SH = 23;

    localparam logic ACT_SPAWN = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [1:0] KIND_SPAWN = 2'd0;
    localparam logic [1:0] KIND_LIVE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CALC,
        ST_SWB,
        ST_TRD,
        ST_TMUL,
        ST_TWB,
        ST_TEND
    } t_state;

    // One pool slot as it lies in the particle memory.
    typedef struct packed {
        logic        [16:0] life;
        logic signed [19:0] px;
        logic signed [19:0] py;
        logic signed [19:0] vx;
        logic signed [19:0] vy;
        logic        [7:0]  shade;
        logic signed [19:0] alpha;
    } t_entry;

    // One result item waiting for the output register.
    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         slot;
        logic signed [19:0] px;
        logic signed [19:0] py;
        logic [7:0]         shade;
        logic signed [18:0] alpha;
    } t_res;

    // Fold a 0..127 draw into 0..99.
    function automatic logic [6:0] fold100(input logic [6:0] raw);
        fold100 = (raw >= 7'd100) ? raw - 7'd100 : raw;
    endfunction

    // (jr-50)*16/10 truncated toward zero, via multiply by 205 and shift by 11.
    function automatic logic signed [7:0] jitter_q4(input logic [6:0] jr);
        logic signed [7:0] d;
        logic [9:0]        u;
        logic [17:0]       p;
        logic [7:0]        q;
        d = $signed({1'b0, jr}) - 8'sd50;
        u = {(d[7] ? 6'(-d) : 6'(d)), 4'b0};
        p = 18'(u) * 18'd205;
        q = 8'(p >> 11);
        jitter_q4 = d[7] ? -$signed(q) : $signed(q);
    endfunction

    // Saturate a 22-bit signed sum to 20 bits.
    function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
        if (v > 22'sd524287) begin
            sat20 = 20'sd524287;
        end else if (v < -22'sd524288) begin
            sat20 = -20'sd524288;
        end else begin
            sat20 = v[19:0];
        end
    endfunction

endpackage

### src/particle_pool_engine.sv
// Particle pool engine: one particle memory with a read-modify-write sequencer.
// Depends on ppe_pkg.
//
// Input channel (i_s_*): one request per item. tuser is the action (0 spawn,
// 1 tick). Requests are taken only while the sequencer is idle, one at a time.
// Output channel (o_m_*): result items, tuser is the kind, tlast marks the last
// result of a request. An output register parts the two channels.
//
// Spawn: next-fit scan of the live bits from the last used slot, one slot per
// cycle, then ST_CALC forms the slot and ST_SWB writes it. The scan length
// sets the latency, apart from any hold at the write-back.
// Tick: a walk over all slots; a dead slot takes only the read state, a live
// slot takes read, multiply and write back (through the single write port),
// and a closing state ends the walk.
// A live result is held in a pending register until the next live one or the
// end of the walk shows whether it is the last. If the receiver stalls, the
// walk holds at the write-back of the next live slot and the spawn holds at
// its write-back; nothing is dropped.
// Reset clears the live bits, the search start and all handshake state; the
// memory contents need no clearing since a slot is read only while live.
module particle_pool_engine #(
    parameter int POOL_SIZE = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // dt[15:0], obj_x, obj_y, obj_vx, obj_vy, offset_x, offset_y (20 each),
    // jitter_raw[6:0], shade_raw[6:0], zero fill to 152 bits
    input  logic [151:0] i_s_tdata,
    // action
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // slot[5:0], pos_x[19:0], pos_y[19:0], brightness[7:0], alpha[18:0],
    // zero fill to 80 bits
    output logic [79:0]  o_m_tdata,
    // kind
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast
);
    import ppe_pkg::*;

    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(POOL_SIZE - 1);

    typedef struct packed {
        logic mem_we;
        logic out_load;
        logic tw_go;
    } t_ctl;

    t_state r_state, n_state;
    t_ctl   ctl;

    logic [POOL_SIZE-1:0] r_live;
    logic [5:0]           r_search_start;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_cnt;
    logic [IW-1:0]        r_slot;

    // Latched request
    logic [15:0] r_dt;
    logic signed [19:0] r_ox, r_oy, r_ovx, r_ovy, r_offx, r_offy;
    logic [6:0]  r_jr, r_sr;

    // Spawn math
    logic signed [19:0] r_sp_px, r_sp_py;
    logic [39:0]        r_qx_prod, r_qy_prod;
    logic               r_vx_neg, r_vy_neg;
    logic [7:0]         r_sp_shade;

    // Memory
    t_entry r_mem [POOL_SIZE];
    t_entry r_rd;
    t_entry wr_data;
    logic [IW-1:0] wr_addr;

    // Tick math
    logic [16:0]        r_life_new;
    logic signed [36:0] r_prod_x, r_prod_y;

    // Pending and output registers
    logic r_pend_valid;
    t_res r_pend;
    logic r_out_valid;
    logic r_out_last;
    t_res r_out;

    logic in_acc, out_free, slot_live, idx_last;
    logic [16:0] life_calc;
    logic signed [20:0] mx, my;
    logic signed [19:0] tw_px, tw_py, tw_alpha;
    logic [17:0] fade;
    logic signed [20:0] alpha_dec;
    logic signed [7:0]  jit;
    logic [IW-1:0] start_idx;
    logic signed [19:0] sp_vx, sp_vy;
    t_res live_res;

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign slot_live  = r_live[r_idx];
    assign idx_last   = (r_idx == IDX_LAST);
    assign start_idx  = ({1'b0, r_search_start} >= 7'(POOL_SIZE)) ? '0
                                                               : r_search_start[IW-1:0];

    // Tick datapath: life subtract, then move and fade from registered products.
    assign life_calc = (r_rd.life > {1'b0, r_dt}) ? r_rd.life - {1'b0, r_dt} : '0;

    always_comb begin
        logic signed [36:0] bx, by;
        bx = r_prod_x + (r_prod_x[36] ? 37'sd65535 : 37'sd0);
        by = r_prod_y + (r_prod_y[36] ? 37'sd65535 : 37'sd0);
        mx = bx[36:16];
        my = by[36:16];
    end

    assign tw_px = sat20({{2{r_rd.px[19]}}, r_rd.px} - {mx[20], mx});
    assign tw_py = sat20({{2{r_rd.py[19]}}, r_rd.py} - {my[20], my});
    assign fade  = 18'(({3'b0, r_dt} + {1'b0, r_dt, 2'b0}) >> 1);
    assign alpha_dec = {r_rd.alpha[19], r_rd.alpha} - {3'b0, fade};
    assign tw_alpha  = (alpha_dec < -21'sd262144) ? -20'sd262144 : alpha_dec[19:0];

    assign live_res = '{kind: KIND_LIVE, slot: 6'(r_idx), px: tw_px, py: tw_py,
                        shade: r_rd.shade, alpha: tw_alpha[18:0]};

    // Spawn datapath
    assign jit   = jitter_q4(fold100(r_jr));
    assign sp_vx = r_vx_neg ? -$signed(20'(r_qx_prod >> RECIP10_SH))
                            : $signed(20'(r_qx_prod >> RECIP10_SH));
    assign sp_vy = r_vy_neg ? -$signed(20'(r_qy_prod >> RECIP10_SH))
                            : $signed(20'(r_qy_prod >> RECIP10_SH));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_s_tuser[0] == ACT_TICK) ? ST_TRD : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (!slot_live || r_cnt == IDX_LAST) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: n_state = ST_SWB;
            ST_SWB: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TRD: begin
                if (slot_live) begin
                    n_state = ST_TMUL;
                end else if (idx_last) begin
                    n_state = ST_TEND;
                end
            end
            ST_TMUL: n_state = ST_TWB;
            ST_TWB: begin
                if (ctl.tw_go) begin
                    n_state = idx_last ? ST_TEND : ST_TRD;
                end
            end
            ST_TEND: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Strobes
    always_comb begin
        ctl.tw_go    = (r_life_new == '0) || !r_pend_valid || out_free;
        ctl.mem_we   = 1'b0;
        ctl.out_load = 1'b0;
        unique case (r_state)
            ST_SWB: begin
                ctl.mem_we   = out_free;
                ctl.out_load = out_free;
            end
            ST_TWB: begin
                ctl.mem_we   = ctl.tw_go && (r_life_new != '0);
                ctl.out_load = ctl.tw_go && (r_life_new != '0) && r_pend_valid;
            end
            ST_TEND: ctl.out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (r_state == ST_SWB) begin
            wr_addr = r_slot;
            wr_data = '{life: 17'(ONE_Q16), px: r_sp_px, py: r_sp_py, vx: sp_vx,
                        vy: sp_vy, shade: r_sp_shade, alpha: 20'(ONE_Q16)};
        end else begin
            wr_addr = r_idx;
            wr_data = '{life: r_life_new, px: tw_px, py: tw_py, vx: r_rd.vx,
                        vy: r_rd.vy, shade: r_rd.shade, alpha: tw_alpha};
        end
    end

    // Particle memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (ctl.mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[r_idx];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dt   <= i_s_tdata[15:0];
            r_ox   <= i_s_tdata[35:16];
            r_oy   <= i_s_tdata[55:36];
            r_ovx  <= i_s_tdata[75:56];
            r_ovy  <= i_s_tdata[95:76];
            r_offx <= i_s_tdata[115:96];
            r_offy <= i_s_tdata[135:116];
            r_jr   <= i_s_tdata[142:136];
            r_sr   <= i_s_tdata[149:143];
        end
        if (r_state == ST_CALC) begin
            r_sp_px    <= sat20(22'(r_ox) + 22'(jit) + 22'(r_offx));
            r_sp_py    <= sat20(22'(r_oy) + 22'(jit) + 22'(r_offy));
            r_vx_neg   <= r_ovx[19];
            r_vy_neg   <= r_ovy[19];
            // magnitude is taken unsigned so the most negative velocity stays 2^19
            r_qx_prod  <= 40'($unsigned(r_ovx[19] ? -r_ovx : r_ovx)) * 40'(RECIP10);
            r_qy_prod  <= 40'($unsigned(r_ovy[19] ? -r_ovy : r_ovy)) * 40'(RECIP10);
            r_sp_shade <= 8'd50 + 8'(fold100(r_sr));
        end
        if (r_state == ST_TMUL) begin
            r_life_new <= life_calc;
            r_prod_x   <= 37'(r_rd.vx) * $signed({1'b0, r_dt});
            r_prod_y   <= 37'(r_rd.vy) * $signed({1'b0, r_dt});
        end
        if (r_state == ST_TWB && ctl.tw_go && r_life_new != '0) begin
            r_pend <= live_res;
        end
        if (ctl.out_load) begin
            unique case (r_state)
                ST_SWB: begin
                    r_out      <= '{kind: KIND_SPAWN, slot: 6'(r_slot), px: r_sp_px,
                                    py: r_sp_py, shade: r_sp_shade,
                                    alpha: 19'(ONE_Q16)};
                    r_out_last <= 1'b1;
                end
                ST_TWB: begin
                    r_out      <= r_pend;
                    r_out_last <= 1'b0;
                end
                default: begin
                    r_out      <= r_pend_valid ? r_pend : '{kind: KIND_EMPTY, default: '0};
                    r_out_last <= 1'b1;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_live         <= '0;
            r_search_start <= '0;
            r_idx          <= '0;
            r_cnt          <= '0;
            r_slot         <= '0;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt        <= '0;
                    r_pend_valid <= 1'b0;
                    r_idx        <= (i_s_tuser[0] == ACT_TICK) ? '0 : start_idx;
                end
                ST_SEARCH: begin
                    if (!slot_live) begin
                        r_slot <= r_idx;
                    end else if (r_cnt == IDX_LAST) begin
                        r_slot <= '0;
                    end else begin
                        r_idx <= idx_last ? '0 : r_idx + 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SWB: begin
                    if (out_free) begin
                        r_live[r_slot] <= 1'b1;
                        r_search_start <= 6'(r_slot);
                    end
                end
                ST_TRD: begin
                    if (!slot_live && !idx_last) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_TWB: begin
                    if (ctl.tw_go) begin
                        if (r_life_new == '0) begin
                            r_live[r_idx] <= 1'b0;
                        end else begin
                            r_pend_valid <= 1'b1;
                        end
                        if (!idx_last) begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {7'b0, r_out.alpha, r_out.shade, r_out.py, r_out.px, r_out.slot};

endmodule

### src/ppe_checker.sv
// Port-level checks for the particle pool engine, bound to the top level.
// Depends on ppe_pkg and particle_pool_engine_assert.svh.
`include "particle_pool_engine_assert.svh"

module ppe_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [79:0]  o_m_tdata,
    input logic [1:0]   o_m_tuser,
    input logic         o_m_tlast
);
    import ppe_pkg::*;

    logic stalled;
    assign stalled = o_m_tvalid && !i_m_tready;

    `PPE_ASSERT_NEXT(a_one_request, i_s_tvalid && o_s_tready, !o_s_tready, "request overlap")
    `PPE_ASSERT_NEXT(a_hold_stall, stalled, o_m_tvalid && $stable(o_m_tdata), "result changed")
    `PPE_ASSERT(a_kind_last, !(o_m_tvalid && o_m_tuser != KIND_LIVE && !o_m_tlast), "no tlast")
    `PPE_ASSERT(a_empty_zero, !(o_m_tvalid && o_m_tuser == KIND_EMPTY && |o_m_tdata), "empty data")
endmodule

bind particle_pool_engine ppe_checker u_ppe_checker (.*);
